@@ hdl/srvm_pkg.sv @@
// ----------------------------------------------------------------------------
// srvm_pkg: shared types and constants
// Opcodes, controller states and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package srvm_pkg;

  localparam int DEF_DATA_WORDS = 256;
  localparam int DEF_REG_COUNT  = 4;
  localparam int PC_W           = 8;
  localparam int WORD_W         = 32;
  localparam int FIELD_W        = 8;
  localparam int CMD_W          = 4;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LOAD  = 4'd4,
    OP_STORE = 4'd5,
    OP_JUMP  = 4'd6,
    OP_BEQ   = 4'd7,
    OP_BGT   = 4'd8,
    OP_BLT   = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_HALT  = 4'd12
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;   // clear one data word and advance the clear counter
    logic capture;      // latch an accepted beat
    logic exec;         // operands ready: compute and commit
    logic div_start;    // start the divider
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic is_div;       // captured beat is a nonzero divide and the machine is not halted
    logic div_done;
  } dp_stat_t;

endpackage

@@ hdl/srvm_if.sv @@
// ----------------------------------------------------------------------------
// srvm_if: channel interfaces
// Valid/ready channels for instructions, results and configuration.
// ----------------------------------------------------------------------------
interface srvm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [7:0]  field_a;
  logic [7:0]  field_b;
  logic [7:0]  field_c;
  logic signed [31:0] input_value;
  modport source (output valid, command, field_a, field_b, field_c, input_value,
                  input ready);
  modport sink   (input valid, command, field_a, field_b, field_c, input_value,
                  output ready);
endinterface

interface srvm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  next_pc;
  logic        out_valid;
  logic signed [31:0] out_value;
  logic        halted;
  logic        div_by_zero;
  logic        bad_command;
  modport source (output valid, next_pc, out_valid, out_value, halted, div_by_zero,
                  bad_command, input ready);
  modport sink   (input valid, next_pc, out_valid, out_value, halted, div_by_zero,
                  bad_command, output ready);
endinterface

interface srvm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/srvm_div.sv @@
// ----------------------------------------------------------------------------
// srvm_div: iterative signed divider
// Restoring divide on magnitudes, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module srvm_div
  import srvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(WORD_W + 1);

  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[WORD_W-1]};
    trial    = shifted - {1'b0, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dvs_nxt  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      cnt_nxt  = CNT_W'(WORD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one restoring step
      if (!trial[WORD_W]) begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (WORD_W'(0) - quo_r) : quo_r;

endmodule

@@ hdl/srvm_datapath.sv @@
// ----------------------------------------------------------------------------
// srvm_datapath: registers, data store and execute logic
// Holds the register file, data store RAM, counter and result register.
// ----------------------------------------------------------------------------
module srvm_datapath
  import srvm_pkg::*;
#(
  parameter int DATA_WORDS = DEF_DATA_WORDS,
  parameter int REG_COUNT  = DEF_REG_COUNT
) (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  srvm_in_if.sink  in_ch,
  srvm_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic [PC_W-1:0] cfg_data
);

  localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CW = AW + 1;

  // data store, one write and one registered read port
  logic [WORD_W-1:0] mem [DATA_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic [WORD_W-1:0] regs_r [REG_COUNT];

  logic [PC_W-1:0]   pc_r;
  logic              halt_r;
  logic [CW-1:0]     clr_r;

  // captured instruction
  logic [CMD_W-1:0]   op_r;
  logic [FIELD_W-1:0] fa_r, fb_r, fc_r;
  logic [WORD_W-1:0]  ival_r;

  // result register
  logic [PC_W-1:0]   o_pc_r;
  logic              o_ov_r, o_halt_r, o_dz_r, o_bad_r;
  logic [WORD_W-1:0] o_val_r;

  logic [RW-1:0]     ia, ib, ic;
  logic [AW-1:0]     addr_a, addr_b, rd_addr;
  logic [WORD_W-1:0] ra, rb, rc;
  logic [2*WORD_W-1:0] prod;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  assign ia     = RW'(fa_r % REG_COUNT);
  assign ib     = RW'(fb_r % REG_COUNT);
  assign ic     = RW'(fc_r % REG_COUNT);
  assign addr_a = AW'(fa_r % DATA_WORDS);
  assign addr_b = AW'(fb_r % DATA_WORDS);
  assign ra     = regs_r[ia];
  assign rb     = regs_r[ib];
  assign rc     = regs_r[ic];
  assign prod   = rb * rc;
  assign rd_addr = (opcode_t'(op_r) == OP_LOAD) ? addr_b : addr_a;

  srvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rb),
    .divisor  (rc),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.clear_last = (clr_r == CW'(DATA_WORDS - 1));
  assign stat.is_div     = !halt_r && (opcode_t'(op_r) == OP_DIV) && (rc != '0);
  assign stat.div_done   = div_done;

  // data store: clear sweep, store and input writes, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_r[AW-1:0]] <= '0;
    end else if (cmd.exec && !halt_r) begin
      if (opcode_t'(op_r) == OP_STORE) mem[addr_a] <= rb;
      else if (opcode_t'(op_r) == OP_IN) mem[addr_a] <= ival_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= '0;
    end else begin
      if (cmd.clear_step) clr_r <= clr_r + CW'(1);
      if (cfg_we) pc_r <= cfg_data;
      if (cmd.exec && !halt_r) begin
        case (op_r)
          OP_ADD:  regs_r[ia] <= rb + rc;
          OP_SUB:  regs_r[ia] <= rb - rc;
          OP_MUL:  regs_r[ia] <= prod[WORD_W-1:0];
          OP_DIV:  if (rc != '0) regs_r[ia] <= div_q;
          OP_LOAD: regs_r[ia] <= rd_data_r;
          default: ;
        endcase
        case (op_r)
          OP_JUMP: pc_r <= fa_r;
          OP_BEQ:  pc_r <= (ra == rb) ? fc_r : pc_r + PC_W'(1);
          OP_BGT:  pc_r <= (!ra[WORD_W-1] && ra != '0) ? fc_r : pc_r + PC_W'(1);
          OP_BLT:  pc_r <= ra[WORD_W-1] ? fc_r : pc_r + PC_W'(1);
          OP_HALT: halt_r <= 1'b1;
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LOAD, OP_STORE, OP_OUT, OP_IN:
            pc_r <= pc_r + PC_W'(1);
          default: ;
        endcase
      end
    end
  end

  // capture beat and build result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_ch.command;
      fa_r   <= in_ch.field_a;
      fb_r   <= in_ch.field_b;
      fc_r   <= in_ch.field_c;
      ival_r <= in_ch.input_value;
    end
    if (cmd.exec) begin
      o_ov_r  <= 1'b0;
      o_val_r <= '0;
      o_dz_r  <= 1'b0;
      o_bad_r <= 1'b0;
      o_halt_r <= halt_r;
      o_pc_r  <= pc_r;
      if (!halt_r) begin
        o_halt_r <= (opcode_t'(op_r) == OP_HALT);
        case (op_r)
          OP_JUMP: o_pc_r <= fa_r;
          OP_BEQ:  o_pc_r <= (ra == rb) ? fc_r : pc_r + PC_W'(1);
          OP_BGT:  o_pc_r <= (!ra[WORD_W-1] && ra != '0) ? fc_r : pc_r + PC_W'(1);
          OP_BLT:  o_pc_r <= ra[WORD_W-1] ? fc_r : pc_r + PC_W'(1);
          OP_HALT: o_pc_r <= pc_r;
          OP_ADD, OP_SUB, OP_MUL, OP_LOAD, OP_STORE, OP_IN:
            o_pc_r <= pc_r + PC_W'(1);
          OP_DIV: begin
            o_pc_r <= pc_r + PC_W'(1);
            o_dz_r <= (rc == '0);
          end
          OP_OUT: begin
            o_pc_r  <= pc_r + PC_W'(1);
            o_ov_r  <= 1'b1;
            o_val_r <= rd_data_r;
          end
          default: o_bad_r <= 1'b1;
        endcase
      end
    end
  end

  assign out_ch.next_pc     = o_pc_r;
  assign out_ch.out_valid   = o_ov_r;
  assign out_ch.out_value   = o_val_r;
  assign out_ch.halted      = o_halt_r;
  assign out_ch.div_by_zero = o_dz_r;
  assign out_ch.bad_command = o_bad_r;

endmodule

@@ hdl/srvm_ctrl.sv @@
// ----------------------------------------------------------------------------
// srvm_ctrl: sequencing state machine
// Clears the store after reset, then steps capture, read, divide and result.
// ----------------------------------------------------------------------------
module srvm_ctrl
  import srvm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        // memory read data valid next cycle; divider starts here for a nonzero divide
        if (stat.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!stat.is_div || stat.div_done) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/small_register_vm_executor.sv @@
// ----------------------------------------------------------------------------
// small_register_vm_executor: one VM instruction per input beat
// Sequence: an accepted beat passes the read and execute states, and a
// nonzero divide the 32-step serial divider, before the result is shown.
// One beat in flight; result waits in a register until it is taken.
// Reset: a clearing pass of DATA_WORDS cycles zeros the data store before
// the first beat is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module small_register_vm_executor
  import srvm_pkg::*;
#(
  parameter int DATA_WORDS = DEF_DATA_WORDS,
  parameter int REG_COUNT  = DEF_REG_COUNT
) (
  input  logic clk,
  input  logic rst_n,
  srvm_in_if.sink    in_ch,
  srvm_out_if.source out_ch,
  srvm_cfg_if.sink   cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  srvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srvm_datapath #(
    .DATA_WORDS (DATA_WORDS),
    .REG_COUNT  (REG_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_ch.valid),
    .cfg_data (cfg_ch.data)
  );

endmodule

@@ hdl/srvm_checker.sv @@
// ----------------------------------------------------------------------------
// srvm_checker: port-level checks
// Watches handshake and result flags at the top-level ports.
// ----------------------------------------------------------------------------
module srvm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_halted,
  input logic out_dz,
  input logic out_bad,
  input logic out_ov
);

  // never take a new beat while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  // a stalled result holds its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // result flags are mutually exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_dz, out_bad, out_ov}))
    else $error("conflicting result flags");

  // no result follows directly on an accept
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  // a halted result carries no other flag
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_dz && !out_bad && !out_ov)
    else $error("flags set on halted result");

endmodule

bind small_register_vm_executor srvm_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_halted (out_ch.halted),
  .out_dz     (out_ch.div_by_zero),
  .out_bad    (out_ch.bad_command),
  .out_ov     (out_ch.out_valid)
);
